FILE: rtl/core/pcvt_pkg.sv
// pcvt_pkg: types, codes and constants shared by the pot and cv change tracker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pcvt_pkg;

   localparam int SAMPLE_BITS           = 10;
   localparam int CHANNEL_BITS          = 4;
   localparam int OP_BITS               = 3;
   localparam int COUNT_BITS            = SAMPLE_BITS + 1;
   localparam int CSR_INDEX_BITS        = 2;
   localparam int CSR_DATA_BITS         = SAMPLE_BITS;
   localparam int DEFAULT_NUM_KNOBS     = 4;
   localparam int DEFAULT_NUM_CV_INPUTS = 5;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_SAMPLE       = 3'd0;
   localparam logic [OP_BITS-1:0] OP_FREEZE_ONE   = 3'd1;
   localparam logic [OP_BITS-1:0] OP_UNFREEZE_ONE = 3'd2;
   localparam logic [OP_BITS-1:0] OP_FREEZE_ALL   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_UNFREEZE_ALL = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANGE_TOLERANCE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNFREEZE_DISTANCE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_LIMIT        = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXTERNAL_UNFREEZE = 2'd3;

   // register reset values
   localparam logic [SAMPLE_BITS-1:0] RESET_CHANGE_TOLERANCE  = 10'd2;
   localparam logic [SAMPLE_BITS-1:0] RESET_UNFREEZE_DISTANCE = 10'd20;
   localparam logic [SAMPLE_BITS-1:0] RESET_IDLE_LIMIT        = 10'd100;
   localparam logic                   RESET_EXTERNAL_UNFREEZE = 1'b0;

   typedef struct packed {
      logic [OP_BITS-1:0]      operation;
      logic [CHANNEL_BITS-1:0] channel;
      logic [SAMPLE_BITS-1:0]  sample;
   } req_item_type;

   typedef struct packed {
      logic                   changed;
      logic                   frozen;
      logic [SAMPLE_BITS-1:0] current_value;
      logic [SAMPLE_BITS-1:0] previous_value;
   } rsp_item_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] change_tolerance;
      logic [SAMPLE_BITS-1:0] unfreeze_distance;
      logic [SAMPLE_BITS-1:0] idle_limit;
      logic                   external_unfreeze;
   } cfg_type;

endpackage

FILE: rtl/core/pot_and_cv_change_tracker.sv
// pot_and_cv_change_tracker: top level, input register, update logic, result register
// depends on pcvt_pkg, pcvt_csr, pcvt_update
//
//   port group   dir     handshake               payload
//   req_         in      req_valid / req_ready   req_item  (operation, channel, sample)
//   rsp_         out     rsp_valid / rsp_ready   rsp_item  (changed, frozen, values)
//   csr_         in      csr_valid / csr_ready   csr_index, csr_data
//
// one item per cycle unless rsp stalls; an item passes both registers before rsp_valid
// the update runs as the item leaves the input register, so the next item sees its state
// a stalled result holds the result register; the input register keeps taking one item
// csr_ready is always high; a register write lands at the edge it is accepted
// synchronous reset loads the register defaults, zero values, all knobs frozen
`timescale 1ns / 1ps

module pot_and_cv_change_tracker #(
   parameter int NUM_KNOBS     = pcvt_pkg::DEFAULT_NUM_KNOBS,
   parameter int NUM_CV_INPUTS = pcvt_pkg::DEFAULT_NUM_CV_INPUTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pcvt_pkg::req_item_type              req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pcvt_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcvt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pcvt_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import pcvt_pkg::*;

   cfg_type      cfg;
   req_item_type stage_item_ff;
   logic         stage_valid_ff;
   logic         stage_valid_in;
   rsp_item_type out_item_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type result;
   logic         advance;
   logic         take;

   assign advance   = stage_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   assign stage_valid_in = take || (stage_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_ready);

   pcvt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pcvt_update #(
      .NUM_KNOBS     (NUM_KNOBS),
      .NUM_CV_INPUTS (NUM_CV_INPUTS)
   ) u_update (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (stage_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

endmodule

FILE: rtl/core/pcvt_csr.sv
// pcvt_csr: configuration registers of the change tracker
// depends on pcvt_pkg
`timescale 1ns / 1ps

module pcvt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pcvt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pcvt_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output pcvt_pkg::cfg_type                    cfg
);
   import pcvt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANGE_TOLERANCE:  cfg_in.change_tolerance  = csr_data;
            CSR_UNFREEZE_DISTANCE: cfg_in.unfreeze_distance = csr_data;
            CSR_IDLE_LIMIT:        cfg_in.idle_limit        = csr_data;
            CSR_EXTERNAL_UNFREEZE: cfg_in.external_unfreeze = csr_data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.change_tolerance  <= RESET_CHANGE_TOLERANCE;
         cfg_ff.unfreeze_distance <= RESET_UNFREEZE_DISTANCE;
         cfg_ff.idle_limit        <= RESET_IDLE_LIMIT;
         cfg_ff.external_unfreeze <= RESET_EXTERNAL_UNFREEZE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/pcvt_update.sv
// pcvt_update: channel state, frozen bits, activity counter and the per-item update
// depends on pcvt_pkg
`timescale 1ns / 1ps

module pcvt_update #(
   parameter int NUM_KNOBS     = pcvt_pkg::DEFAULT_NUM_KNOBS,
   parameter int NUM_CV_INPUTS = pcvt_pkg::DEFAULT_NUM_CV_INPUTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  pcvt_pkg::req_item_type item,
   input  pcvt_pkg::cfg_type      cfg,
   output pcvt_pkg::rsp_item_type result
);
   import pcvt_pkg::*;

   localparam int NUM_CHANNELS = NUM_KNOBS + NUM_CV_INPUTS;
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int KNOB_W       = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;

   logic [SAMPLE_BITS-1:0] value_ff [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] value_in [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] prev_ff  [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] prev_in  [NUM_CHANNELS];
   logic [NUM_KNOBS-1:0]   frozen_ff;
   logic [NUM_KNOBS-1:0]   frozen_in;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;

   logic [CH_W-1:0]        ch_idx;
   logic [KNOB_W-1:0]      knob_idx;
   logic                   in_range;
   logic                   is_knob;
   logic [SAMPLE_BITS-1:0] cur_val;
   logic [SAMPLE_BITS-1:0] delta;
   logic                   pickup;
   logic                   changed;

   assign ch_idx   = CH_W'(item.channel);
   assign knob_idx = KNOB_W'(item.channel);
   assign in_range = int'(item.channel) < NUM_CHANNELS;
   assign is_knob  = int'(item.channel) < NUM_KNOBS;
   assign cur_val  = value_ff[ch_idx];
   assign delta    = (item.sample > cur_val) ? (item.sample - cur_val)
                                             : (cur_val - item.sample);
   assign pickup   = is_knob && !cfg.external_unfreeze && frozen_ff[knob_idx]
                     && (delta > cfg.unfreeze_distance);

   always_comb begin
      value_in  = value_ff;
      prev_in   = prev_ff;
      frozen_in = frozen_ff;
      count_in  = count_ff;
      changed   = 1'b0;
      if (in_range) begin
         unique case (item.operation)
            OP_SAMPLE: begin
               changed = pickup;
               if (pickup) begin
                  frozen_in[knob_idx] = 1'b0;
               end
               if (delta > cfg.change_tolerance) begin
                  changed  = 1'b1;
                  count_in = '0;
               end else if (count_ff > COUNT_BITS'(cfg.idle_limit)) begin
                  changed  = 1'b0;
               end else begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
               prev_in[ch_idx]  = cur_val;
               value_in[ch_idx] = item.sample;
            end
            OP_FREEZE_ONE: begin
               if (is_knob) begin
                  frozen_in[knob_idx] = 1'b1;
               end
            end
            OP_UNFREEZE_ONE: begin
               if (is_knob) begin
                  frozen_in[knob_idx] = 1'b0;
               end
            end
            OP_FREEZE_ALL:   frozen_in = '1;
            OP_UNFREEZE_ALL: frozen_in = '0;
            default:         frozen_in = frozen_ff;
         endcase
      end
   end

   always_comb begin
      result = '0;
      if (in_range) begin
         result.changed        = changed;
         result.frozen         = is_knob && frozen_in[knob_idx];
         result.current_value  = value_in[ch_idx];
         result.previous_value = prev_in[ch_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            value_ff[i] <= '0;
            prev_ff[i]  <= '0;
         end
         frozen_ff <= '1;
         count_ff  <= '0;
      end else if (fire) begin
         value_ff  <= value_in;
         prev_ff   <= prev_in;
         frozen_ff <= frozen_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/pcvt_checker.sv
// pcvt_checker: port-level assertions for the change tracker, bound to the top level
// depends on pcvt_pkg and pot_and_cv_change_tracker
`timescale 1ns / 1ps

module pcvt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input pcvt_pkg::rsp_item_type rsp_item
);
   import pcvt_pkg::*;

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_item))
      else $error("rsp_item changed while stalled");

   // a changed mark always comes with a new value
   a_changed_moves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.changed |-> rsp_item.current_value != rsp_item.previous_value)
      else $error("changed item with equal current and previous value");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind pot_and_cv_change_tracker pcvt_checker u_pcvt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
